// ===== rtl/bte_pkg.sv =====
// Shared types, codes and conversion functions for the BCD time-set editor.
// No dependencies; every other file in rtl/ refers to this package by scoped name.

package bte_pkg;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_KEY   = 1'b1;

  // Key codes
  localparam logic [2:0] KP_TIMEOUT = 3'd0;
  localparam logic [2:0] KP_MODE    = 3'd1;
  localparam logic [2:0] KP_HOME    = 3'd2;
  localparam logic [2:0] KP_UP      = 3'd3;
  localparam logic [2:0] KP_DOWN    = 3'd4;
  localparam logic [2:0] KP_ENTER   = 3'd5;

  // Status codes
  localparam logic [2:0] ST_EDITING = 3'd0;
  localparam logic [2:0] ST_ABORTED = 3'd1;
  localparam logic [2:0] ST_UNSAVED = 3'd2;
  localparam logic [2:0] ST_SAVED   = 3'd3;
  localparam logic [2:0] ST_IDLE    = 3'd4;

  // Field select codes
  localparam logic FIELD_HOUR   = 1'b0;
  localparam logic FIELD_MINUTE = 1'b1;

  // Field limits
  localparam logic [7:0] HOUR_LIMIT   = 8'd23;
  localparam logic [7:0] MINUTE_LIMIT = 8'd59;

  // Payload widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  // One input item
  typedef struct packed {
    logic        command;
    logic [15:0] start_bcd;
    logic [2:0]  key_code;
  } item_t;

  // One result item
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  hour_value;
    logic [7:0]  minute_value;
    logic        field_select;
    logic [15:0] result_bcd;
  } result_t;

  // Two BCD nibbles to binary, each nibble at face value (0..165)
  function automatic logic [7:0] bcd_byte_to_bin(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]};
    return (tens << 3) + (tens << 1) + {4'd0, b[3:0]};
  endfunction

  // Binary byte to three BCD digits; divide by ten via multiply by 205 >> 11
  function automatic logic [11:0] bin8_to_bcd3(input logic [7:0] v);
    logic [15:0] p1;
    logic [4:0]  q1;
    logic [7:0]  r1;
    logic [15:0] p2;
    logic [1:0]  q2;
    logic [4:0]  r2;
    p1 = {8'd0, v} * 16'd205;
    q1 = p1[15:11];
    r1 = v - ({3'd0, q1} * 8'd10);
    p2 = {11'd0, q1} * 16'd205;
    q2 = p2[12:11];
    r2 = q1 - ({3'd0, q2} * 5'd10);
    return {2'd0, q2, r2[3:0], r1[3:0]};
  endfunction

endpackage

// ===== rtl/bcd_time_set_editor_top.sv =====
// Top level of the BCD time-set editor: input register, editor core, result register.
// Depends on bte_pkg, bte_input_stage, bte_edit_core and bte_output_stage.
//
//  channel  | direction | tdata (low bit up)                         | tuser
//  ---------+-----------+--------------------------------------------+-------------
//  s_*      | in        | start_bcd[15:0], key_code[18:16]           | command
//  m_*      | out       | hour_value[7:0], minute_value[15:8],       | status[2:0]
//           |           | field_select[16], result_bcd[32:17]        |
//
// One item per cycle sustained while m_tready stays high; an input transfer reaches
// the result port through the input register and then the result register around
// the core, and a low m_tready can hold it in either.
// Reset (rst, synchronous) empties both registers and returns the editor to idle.
// While m_tready is low the result register holds and the input register still
// takes one more item; s_tready falls only when both are full.

module bcd_time_set_editor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bte_pkg::IN_DATA_W-1:0]  s_tdata,  // start_bcd, key_code
  input  logic                          s_tuser,  // command
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bte_pkg::OUT_DATA_W-1:0] m_tdata,  // hour, minute, field, result_bcd
  output logic [2:0]                    m_tuser   // status
);

  logic             take;
  logic             fire;
  bte_pkg::item_t   item;
  bte_pkg::result_t result;

  bte_input_stage u_input (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .take     (take),
    .fire     (fire),
    .item     (item)
  );

  bte_edit_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  bte_output_stage u_output (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .result   (result),
    .take     (take),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/bte_input_stage.sv =====
// Input register of the BCD time-set editor: holds one accepted transfer.
// Depends on bte_pkg for the item type.

module bte_input_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bte_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                        s_tuser,
  input  logic                        take,
  output logic                        fire,
  output bte_pkg::item_t              item
);

  logic in_valid;

  // Free when empty or when the held item moves on this cycle
  assign s_tready = !in_valid || take;
  assign fire     = in_valid && take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.command   <= s_tuser;
      item.start_bcd <= s_tdata[15:0];
      item.key_code  <= s_tdata[18:16];
    end
  end

endmodule

// ===== rtl/bte_edit_core.sv =====
// Editor state and per-item next-state logic of the BCD time-set editor.
// Depends on bte_pkg for codes, limits and BCD conversion functions.

module bte_edit_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  bte_pkg::item_t  item,
  output bte_pkg::result_t result
);

  logic       active;
  logic       active_next;
  logic [7:0] hour;
  logic [7:0] hour_next;
  logic [7:0] minute;
  logic [7:0] minute_next;
  logic       field;
  logic       field_next;

  logic [7:0]  sel_val;
  logic [7:0]  sel_lim;
  logic [8:0]  up_sum;
  logic [7:0]  dn_val;
  logic [7:0]  up_res;
  logic [7:0]  dn_res;
  logic [11:0] hour_bcd;
  logic [11:0] minute_bcd;
  logic [4:0]  d2_sum;
  logic        d2_carry;
  logic [3:0]  d2;
  logic [4:0]  d3_sum;
  logic [3:0]  d3;
  logic [15:0] save_bcd;

  // Up and down on the selected field
  assign sel_val = (field == bte_pkg::FIELD_MINUTE) ? minute : hour;
  assign sel_lim = (field == bte_pkg::FIELD_MINUTE) ? bte_pkg::MINUTE_LIMIT
                                                    : bte_pkg::HOUR_LIMIT;
  assign up_sum  = {1'b0, sel_val} + 9'd1;
  assign up_res  = (up_sum > {1'b0, sel_lim}) ? 8'd0 : up_sum[7:0];
  assign dn_val  = sel_val - 8'd1;
  assign dn_res  = (sel_val == 8'd0 || dn_val > sel_lim) ? sel_lim : dn_val;

  // Saved word: BCD(hour) shifted two digits plus BCD(minute), low four digits
  assign hour_bcd   = bte_pkg::bin8_to_bcd3(hour);
  assign minute_bcd = bte_pkg::bin8_to_bcd3(minute);
  assign d2_sum     = {1'b0, hour_bcd[3:0]} + {1'b0, minute_bcd[11:8]};
  assign d2_carry   = (d2_sum >= 5'd10);
  assign d2         = d2_carry ? 4'(d2_sum - 5'd10) : d2_sum[3:0];
  assign d3_sum     = {1'b0, hour_bcd[7:4]} + {4'd0, d2_carry};
  assign d3         = (d3_sum >= 5'd10) ? 4'(d3_sum - 5'd10) : d3_sum[3:0];
  assign save_bcd   = {d3, d2, minute_bcd[7:4], minute_bcd[3:0]};

  // Next state and result for the item at the input register
  always_comb begin
    active_next         = active;
    hour_next           = hour;
    minute_next         = minute;
    field_next          = field;
    result.status       = bte_pkg::ST_EDITING;
    result.result_bcd   = 16'd0;
    if (item.command == bte_pkg::CMD_START) begin
      hour_next   = bte_pkg::bcd_byte_to_bin(item.start_bcd[15:8]);
      minute_next = bte_pkg::bcd_byte_to_bin(item.start_bcd[7:0]);
      field_next  = bte_pkg::FIELD_HOUR;
      active_next = 1'b1;
    end else if (!active) begin
      result.status = bte_pkg::ST_IDLE;
    end else begin
      unique case (item.key_code)
        bte_pkg::KP_TIMEOUT, bte_pkg::KP_MODE: begin
          result.status = bte_pkg::ST_ABORTED;
          active_next   = 1'b0;
        end
        bte_pkg::KP_HOME: begin
          result.status = bte_pkg::ST_UNSAVED;
          active_next   = 1'b0;
        end
        bte_pkg::KP_UP: begin
          if (field == bte_pkg::FIELD_MINUTE) minute_next = up_res;
          else hour_next = up_res;
        end
        bte_pkg::KP_DOWN: begin
          if (field == bte_pkg::FIELD_MINUTE) minute_next = dn_res;
          else hour_next = dn_res;
        end
        bte_pkg::KP_ENTER: begin
          if (field == bte_pkg::FIELD_HOUR) begin
            field_next = bte_pkg::FIELD_MINUTE;
          end else begin
            result.status     = bte_pkg::ST_SAVED;
            result.result_bcd = save_bcd;
            active_next       = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    result.hour_value   = hour_next;
    result.minute_value = minute_next;
    result.field_select = field_next;
  end

  // Commit state when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      hour   <= 8'd0;
      minute <= 8'd0;
      field  <= bte_pkg::FIELD_HOUR;
    end else if (fire) begin
      active <= active_next;
      hour   <= hour_next;
      minute <= minute_next;
      field  <= field_next;
    end
  end

endmodule

// ===== rtl/bte_output_stage.sv =====
// Result register of the BCD time-set editor: holds one result until transferred.
// Depends on bte_pkg for the result type and output width.

module bte_output_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  bte_pkg::result_t              result,
  output logic                          take,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bte_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]                    m_tuser
);

  bte_pkg::result_t held;

  // Room for a new result when empty or draining this cycle
  assign take = !m_tvalid || m_tready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Capture result
  always_ff @(posedge clk) begin
    if (fire) begin
      held <= result;
    end
  end

  // Pack fields, lowest first, zero pad to whole bytes
  assign m_tdata = {7'd0, held.result_bcd, held.field_select,
                    held.minute_value, held.hour_value};
  assign m_tuser = held.status;

endmodule

// ===== verif/bcd_time_set_editor_top_tb.sv =====
// Self-checking testbench for bcd_time_set_editor_top: keypad sessions in, checked results out.
// Depends on bte_pkg and the editor RTL; predicts each result with its own model of the editor.

module bcd_time_set_editor_top_tb;

  localparam logic [2:0] KP_OTHER = 3'd6;
  localparam logic [2:0] KP_SPARE = 3'd7;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 300;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [bte_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [bte_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [2:0]                     m_tuser;

  // Editor state as the predictor sees it
  logic [7:0] ed_hour   = 8'd0;
  logic [7:0] ed_minute = 8'd0;
  logic       ed_field  = bte_pkg::FIELD_HOUR;
  logic       ed_active = 1'b0;

  bte_pkg::result_t expected_results[$];
  int unsigned      items_sent  = 0;
  int unsigned      mismatches  = 0;
  int unsigned      cycle_count = 0;
  bit               idle_en     = 1'b1;
  int               hold_len    = 0;

  bcd_time_set_editor_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bcd_time_set_editor_top_tb failed");
      $finish;
    end
  end

  // Binary value to four BCD digits, keeping only the low 16 bits
  function automatic logic [15:0] hhmm_to_bcd(input int unsigned v);
    logic [15:0] r;
    r = '0;
    for (int k = 0; k < 4; k++) begin
      r[4*k +: 4] = 4'(v % 10);
      v = v / 10;
    end
    return r;
  endfunction

  // Two BCD nibbles to binary, each nibble taken at face value
  function automatic logic [7:0] bcd_pair_value(input logic [7:0] b);
    return 8'(b[7:4] * 10 + b[3:0]);
  endfunction

  // Advance the predicted editor by one accepted item and return its result
  function automatic bte_pkg::result_t editor_predict(input bte_pkg::item_t it);
    bte_pkg::result_t r;
    logic [7:0]       lim;
    logic [7:0]       cur;
    r = '0;
    r.status = bte_pkg::ST_EDITING;
    lim = (ed_field == bte_pkg::FIELD_MINUTE) ? bte_pkg::MINUTE_LIMIT : bte_pkg::HOUR_LIMIT;
    cur = (ed_field == bte_pkg::FIELD_MINUTE) ? ed_minute : ed_hour;
    if (it.command == bte_pkg::CMD_START) begin
      ed_hour   = bcd_pair_value(it.start_bcd[15:8]);
      ed_minute = bcd_pair_value(it.start_bcd[7:0]);
      ed_field  = bte_pkg::FIELD_HOUR;
      ed_active = 1'b1;
    end else if (!ed_active) begin
      r.status = bte_pkg::ST_IDLE;
    end else begin
      case (it.key_code)
        bte_pkg::KP_TIMEOUT, bte_pkg::KP_MODE: begin
          r.status  = bte_pkg::ST_ABORTED;
          ed_active = 1'b0;
        end
        bte_pkg::KP_HOME: begin
          r.status  = bte_pkg::ST_UNSAVED;
          ed_active = 1'b0;
        end
        bte_pkg::KP_UP: begin
          cur = ({1'b0, cur} + 9'd1 > {1'b0, lim}) ? 8'd0 : cur + 8'd1;
        end
        bte_pkg::KP_DOWN: begin
          cur = (cur == 8'd0 || cur - 8'd1 > lim) ? lim : cur - 8'd1;
        end
        bte_pkg::KP_ENTER: begin
          if (ed_field == bte_pkg::FIELD_HOUR) begin
            ed_field = bte_pkg::FIELD_MINUTE;
          end else begin
            r.result_bcd = hhmm_to_bcd(ed_hour * 100 + ed_minute);
            r.status     = bte_pkg::ST_SAVED;
            ed_active    = 1'b0;
          end
        end
        default: ;
      endcase
      // Write back the field that up or down touched
      if (it.key_code == bte_pkg::KP_UP || it.key_code == bte_pkg::KP_DOWN) begin
        if (ed_field == bte_pkg::FIELD_MINUTE) ed_minute = cur;
        else ed_hour = cur;
      end
    end
    r.hour_value   = ed_hour;
    r.minute_value = ed_minute;
    r.field_select = ed_field;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
    mismatches++;
  endtask

  // Offer one item, hold it until the transfer, then queue its prediction
  task automatic send_item(input bte_pkg::item_t it);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, it.key_code, it.start_bcd};
    s_tuser  <= it.command;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(editor_predict(it));
    items_sent++;
  endtask

  // Start editing; the key field carries junk
  task automatic send_start(input logic [15:0] bcd);
    bte_pkg::item_t it;
    it.command   = bte_pkg::CMD_START;
    it.start_bcd = bcd;
    it.key_code  = 3'($urandom_range(0, 7));
    send_item(it);
  endtask

  // Key event; the start field carries junk
  task automatic send_key(input logic [2:0] key);
    bte_pkg::item_t it;
    it.command   = bte_pkg::CMD_KEY;
    it.start_bcd = 16'($urandom_range(0, 65535));
    it.key_code  = key;
    send_item(it);
  endtask

  function automatic logic [2:0] pick_edit_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return bte_pkg::KP_UP;
    if (r < 8) return bte_pkg::KP_DOWN;
    return (r == 8) ? KP_OTHER : KP_SPARE;
  endfunction

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin : check_result
    bte_pkg::result_t got;
    bte_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status       = m_tuser;
      got.hour_value   = m_tdata[7:0];
      got.minute_value = m_tdata[15:8];
      got.field_select = m_tdata[16];
      got.result_bcd   = m_tdata[32:17];
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, status", got.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", got.status, want.status);
        if (got.hour_value != want.hour_value)
          report_mismatch("hour_value", got.hour_value, want.hour_value);
        if (got.minute_value != want.minute_value)
          report_mismatch("minute_value", got.minute_value, want.minute_value);
        if (got.field_select != want.field_select)
          report_mismatch("field_select", got.field_select, want.field_select);
        if (got.result_bcd != want.result_bcd)
          report_mismatch("result_bcd", got.result_bcd, want.result_bcd);
      end
    end
  end

  // Drive the result side: random stalls, plus one long hold when requested
  initial begin
    forever begin
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Extremes, every key and the corner cases of the editor
  task automatic test_directed();
    send_key(bte_pkg::KP_UP);        // key while idle
    send_key(KP_SPARE);
    send_start(16'h2359);
    send_key(bte_pkg::KP_UP);        // hour wraps past its limit
    send_key(bte_pkg::KP_DOWN);      // down from zero goes to the limit
    send_key(bte_pkg::KP_ENTER);
    send_key(bte_pkg::KP_UP);        // minute wraps
    send_key(bte_pkg::KP_DOWN);
    send_key(KP_OTHER);
    send_key(KP_SPARE);
    send_key(bte_pkg::KP_ENTER);     // save 23:59
    send_start(16'hFFFF);            // non-decimal digits on both fields
    send_key(bte_pkg::KP_ENTER);
    send_key(bte_pkg::KP_ENTER);     // save truncated to four digits
    send_start(16'hFFFF);
    send_key(bte_pkg::KP_UP);        // above limit goes to zero
    send_key(bte_pkg::KP_ENTER);
    send_key(bte_pkg::KP_DOWN);      // above limit goes to the limit
    send_key(bte_pkg::KP_HOME);
    send_start(16'h1234);
    send_start(16'h0910);            // restart while editing
    send_key(bte_pkg::KP_TIMEOUT);
    send_start(16'h0000);
    send_key(bte_pkg::KP_MODE);
    send_key(bte_pkg::KP_DOWN);      // idle again after abort
  endtask

  // Editing sessions with random content; some start from arbitrary words, some end with no closing key
  task automatic test_sessions(input int unsigned target);
    logic [15:0] bcd;
    int          n;
    int          r;
    while (items_sent < target) begin
      r = $urandom_range(0, 9);
      if (r < 3) bcd = 16'($urandom_range(0, 65535));
      else bcd = hhmm_to_bcd($urandom_range(0, 23) * 100 + $urandom_range(0, 59));
      send_start(bcd);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 8);
      repeat (n) send_key(pick_edit_key());
      if ($urandom_range(0, 7) != 0) begin
        send_key(bte_pkg::KP_ENTER);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 130) : $urandom_range(0, 8);
        repeat (n) send_key(pick_edit_key());
      end
      r = $urandom_range(0, 9);
      if (r < 6) send_key(bte_pkg::KP_ENTER);
      else if (r == 6) send_key(bte_pkg::KP_HOME);
      else if (r == 7) send_key(bte_pkg::KP_TIMEOUT);
      else if (r == 8) send_key(bte_pkg::KP_MODE);
    end
  endtask

  // Arbitrary items in any order
  task automatic test_noise(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) send_start(16'($urandom_range(0, 65535)));
      else send_key(3'($urandom_range(0, 7)));
    end
  endtask

  // Hold the result side off long enough that the input side stalls
  task automatic test_backpressure();
    idle_en  = 1'b0;
    hold_len = HOLD_CYCLES;
    send_start(hhmm_to_bcd($urandom_range(0, 23) * 100 + $urandom_range(0, 59)));
    repeat (30) send_key(pick_edit_key());
    send_key(bte_pkg::KP_ENTER);
    repeat (30) send_key(pick_edit_key());
    send_key(bte_pkg::KP_ENTER);
    idle_en = 1'b1;
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= bte_pkg::CMD_START;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_sessions(900);
    test_backpressure();
    test_noise(200);
    test_sessions(1600);
    idle_en = 1'b0;
    test_sessions(1750);

    // Drain the block before judging the run
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("bcd_time_set_editor_top_tb passed");
    else
      $display("bcd_time_set_editor_top_tb failed");
    $finish;
  end

endmodule

// ===== bcd_time_set_editor_top.f =====
rtl/bte_pkg.sv
rtl/bte_input_stage.sv
rtl/bte_edit_core.sv
rtl/bte_output_stage.sv
rtl/bcd_time_set_editor_top.sv
verif/bcd_time_set_editor_top_tb.sv
